// ===== sv/awm_pkg.sv =====
// Package for the ADC window mean and altitude block.
// Holds the channel payload types, the controller command and status structs,
// and the fixed constants. It depends on nothing else.
`timescale 1ns / 1ps

package awm_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 12;
    localparam int DROP_W   = 12;
    localparam int PCT_W    = 8;

    // Default window length and the reset value of the drop register.
    localparam int                  WINDOW_DEFAULT = 20;
    localparam logic [DROP_W-1:0]   DROP_RESET     = 12'd1017;

    // Percent arithmetic.
    localparam int                  PCT_SCALE      = 100;
    localparam int                  PROD_W         = 19;   // 4095 * 100 fits in 19 bits
    localparam logic [PCT_W-1:0]    PCT_FULL       = 8'sd100;
    localparam logic [PCT_W-1:0]    PCT_SAT        = 8'h80; // -128
    localparam logic [PCT_W-1:0]    PCT_NONE       = 8'd0;
    localparam int                  Q_LIMIT        = 228;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_RECAL  = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } awm_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [SAMPLE_W-1:0]     mean;
        logic signed [PCT_W-1:0] altitude_percent;
        logic                    calibrated;
    } awm_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic calc_mean;
        logic div_start_pct;
        logic capture;
        logic scale;
        logic pct_write;
        logic load_out;
    } awm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic need_div;
        logic out_free;
    } awm_status_t;

endpackage

// ===== sv/adc_window_mean_altitude.sv =====
// Top level of the ADC window mean and altitude block.
// Joins the controller and the datapath. Depends on awm_pkg, awm_ctrl, awm_datapath.
//
//   channel   ports                          payload
//   input     s_valid / s_ready / s_data     kind, sample
//   result    m_valid / m_ready / m_data     mean, altitude_percent, calibrated
//   config    cfg_wr_en / cfg_wr_data        drop
//
// One transaction at a time. A transaction takes longer when a percent division is needed;
// the percent division by the drop register, one quotient bit per cycle, sets this.
// The mean comes from a reciprocal multiply.
// Reset is synchronous and active low; the window reads as zero after reset.
// A result waiting in the output register does not block the next input transaction,
// but a finished transaction waits in its last state until the output register is free.
`timescale 1ns / 1ps

module adc_window_mean_altitude #(
    parameter int WINDOW = awm_pkg::WINDOW_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  awm_pkg::awm_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output awm_pkg::awm_out_t           m_data,
    input  logic                        cfg_wr_en,
    input  logic [awm_pkg::DROP_W-1:0]  cfg_wr_data
);

    import awm_pkg::*;

    awm_cmd_t    cmd;
    awm_status_t status;

    // Sequencer.
    awm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // Window, divider and result logic.
    awm_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

// ===== sv/awm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the sample window. Depends on nothing else.
`timescale 1ns / 1ps

module awm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/awm_datapath.sv =====
// Datapath of the ADC window mean and altitude block: window RAM, running sum,
// reciprocal multiply for the mean, restoring divider for the percent, reference
// capture, percent logic and output register. Depends on awm_pkg and awm_ram.
`timescale 1ns / 1ps

module awm_datapath #(
    parameter int WINDOW = awm_pkg::WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  awm_pkg::awm_cmd_t               cmd,
    output awm_pkg::awm_status_t            status,
    input  awm_pkg::awm_in_t                s_data,
    input  logic                            cfg_wr_en,
    input  logic [awm_pkg::DROP_W-1:0]      cfg_wr_data,
    input  logic                            m_ready,
    output logic                            m_valid,
    output awm_pkg::awm_out_t               m_data
);

    import awm_pkg::*;

    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_MAX    = WINDOW * ((1 << SAMPLE_W) - 1);
    localparam int SUM_W      = $clog2(SUM_MAX + 1);
    localparam int HALF       = WINDOW / 2;
    localparam int MEAN_DVD_W = $clog2(SUM_MAX + HALF + 1);
    localparam int DIV_W      = PROD_W;
    localparam int CNT_W      = $clog2(DIV_W + 1);

    // Reciprocal of the window length: floor(2^RECIP_SH / WINDOW) + 1 with
    // RECIP_SH = dividend bits + ceil(log2(WINDOW)) gives the exact floor quotient
    // for every dividend that fits in MEAN_DVD_W bits.
    localparam int                RECIP_SH = MEAN_DVD_W + $clog2(WINDOW);
    localparam int                RECIP_W  = MEAN_DVD_W + 1;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SH) / WINDOW + 1);
    localparam int                MPROD_W  = MEAN_DVD_W + RECIP_W;

    // Latched item.
    logic                kind_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Window state.
    logic [SLOT_W-1:0]   slot_reg;
    logic [WINDOW-1:0]   valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] old_sample;
    logic                ram_we;

    // Mean by reciprocal multiplication.
    logic [MEAN_DVD_W-1:0] mean_dvd;
    logic [MPROD_W-1:0]    mean_prod;
    logic [SAMPLE_W-1:0]   mean_quot;

    // Reference and configuration.
    logic [DROP_W-1:0]   drop_reg;
    logic [SAMPLE_W-1:0] landed_reg;
    logic                have_ref_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [PROD_W-1:0]   prod_reg;

    // Divider.
    logic [DIV_W-1:0]    dvd_reg;
    logic [DIV_W-1:0]    dvd_next;
    logic [DROP_W-1:0]   rem_reg;
    logic [DROP_W-1:0]   rem_next;
    logic [DROP_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic [DROP_W:0]     rem_shift;
    logic [DROP_W:0]     rem_diff;

    // Percent helpers.
    logic [SAMPLE_W-1:0] bottom;
    logic [SAMPLE_W-1:0] above;
    logic                landed_low;
    logic                mean_low;
    logic                drop_zero;
    logic [SAMPLE_W-1:0] new_mean;

    // Output register.
    logic                m_valid_reg;
    awm_out_t            m_data_reg;

    awm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign old_sample = valid_reg[slot_reg] ? ram_rdata : '0;
    assign ram_we     = cmd.update && (kind_reg == KIND_SAMPLE);

    // Item latch, window update and drop register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= '0;
            sum_reg   <= '0;
            drop_reg  <= DROP_RESET;
        end else begin
            if (cfg_wr_en) begin
                drop_reg <= cfg_wr_data;
            end
            if (ram_we) begin
                sum_reg <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                valid_reg[slot_reg] <= 1'b1;
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_reg <= '0;
                end else begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg   <= s_data.kind;
            sample_reg <= s_data.sample;
        end
    end

    // Rounded mean: (sum + WINDOW/2) times the reciprocal, top bits kept.
    assign mean_dvd  = MEAN_DVD_W'(sum_reg) + MEAN_DVD_W'(HALF);
    assign mean_prod = MPROD_W'(mean_dvd) * MPROD_W'(RECIP);
    assign mean_quot = mean_prod[RECIP_SH +: SAMPLE_W];

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        if (rem_shift >= {1'b0, dvs_reg}) begin
            rem_next = rem_diff[DROP_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
        end else begin
            rem_next = rem_shift[DROP_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
        end
    end

    // Percent divider, one quotient bit per cycle; the register also carries the mean.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.calc_mean) begin
            dvd_reg  <= DIV_W'(mean_quot);
        end else if (cmd.div_start_pct) begin
            dvd_reg  <= DIV_W'(prod_reg);
            dvs_reg  <= drop_reg;
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(DIV_W);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Percent decision terms, from the captured reference and the live drop.
    assign new_mean   = dvd_reg[SAMPLE_W-1:0];
    assign bottom     = landed_reg - drop_reg;
    assign above      = mean_reg - bottom;
    assign landed_low = landed_reg < drop_reg;
    assign mean_low   = mean_reg < bottom;
    assign drop_zero  = (drop_reg == '0);

    // Mean capture, reference capture and percent result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_ref_reg <= 1'b0;
            landed_reg   <= '0;
        end else if (cmd.capture) begin
            if ((kind_reg == KIND_RECAL) || (!have_ref_reg && (new_mean != '0))) begin
                landed_reg   <= new_mean;
                have_ref_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mean_reg <= new_mean;
        end
        if (cmd.scale) begin
            prod_reg <= PROD_W'(above) * PROD_W'(PCT_SCALE);
            if (!have_ref_reg) begin
                pct_reg <= PCT_NONE;
            end else if (landed_low || mean_low) begin
                pct_reg <= PCT_FULL;
            end else if (drop_zero) begin
                pct_reg <= (mean_reg > bottom) ? PCT_SAT : PCT_FULL;
            end else begin
                pct_reg <= PCT_NONE;
            end
        end else if (cmd.pct_write) begin
            if (dvd_reg > DIV_W'(Q_LIMIT)) begin
                pct_reg <= PCT_SAT;
            end else begin
                pct_reg <= PCT_FULL - dvd_reg[PCT_W-1:0];
            end
        end
    end

    // Output register parts the result channel from the work in progress.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.mean             <= mean_reg;
            m_data_reg.altitude_percent <= pct_reg;
            m_data_reg.calibrated       <= have_ref_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.div_done = busy_reg && (cnt_reg == CNT_W'(1));
    assign status.need_div = have_ref_reg && !landed_low && !mean_low && !drop_zero;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ===== sv/awm_ctrl.sv =====
// Controller of the ADC window mean and altitude block: a one-hot state machine
// that steps one transaction through the datapath. Depends on awm_pkg.
`timescale 1ns / 1ps

module awm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  awm_pkg::awm_status_t  status,
    output logic                  s_ready,
    output awm_pkg::awm_cmd_t     cmd
);

    import awm_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b0_0000_0001,
        ST_READ    = 9'b0_0000_0010,
        ST_MSTART  = 9'b0_0000_0100,
        ST_CAPTURE = 9'b0_0000_1000,
        ST_SCALE   = 9'b0_0001_0000,
        ST_PSTART  = 9'b0_0010_0000,
        ST_PDIV    = 9'b0_0100_0000,
        ST_PWRITE  = 9'b0_1000_0000,
        ST_FINISH  = 9'b1_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.update = 1'b1;
                state_next = ST_MSTART;
            end
            ST_MSTART: begin
                cmd.calc_mean = 1'b1;
                state_next    = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                cmd.capture = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = status.need_div ? ST_PSTART : ST_FINISH;
            end
            ST_PSTART: begin
                cmd.div_start_pct = 1'b1;
                state_next        = ST_PDIV;
            end
            ST_PDIV: begin
                if (status.div_done) begin
                    state_next = ST_PWRITE;
                end
            end
            ST_PWRITE: begin
                cmd.pct_write = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/awm_checker.sv =====
// Port-level checker for the ADC window mean and altitude block, bound to the top level.
// Depends on awm_pkg and adc_window_mean_altitude.
`timescale 1ns / 1ps

module awm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input awm_pkg::awm_out_t  m_data
);

    import awm_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result payload changed while stalled");

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after a transaction");

    // Before calibration the percent is zero.
    a_uncal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.calibrated |-> m_data.altitude_percent == PCT_NONE)
        else $error("percent nonzero before calibration");

    // The percent never exceeds full altitude.
    a_pct_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.altitude_percent <= $signed(PCT_FULL))
        else $error("percent above one hundred");

endmodule

bind adc_window_mean_altitude awm_checker u_awm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
